@@ rtl/core/dds_pkg.sv @@
package dds_pkg;

  // transform size and storage
  localparam int MAX_LEN = 64;
  localparam int LEN_W   = 7;
  localparam int IDX_W   = 6;

  // sine table geometry
  localparam int SINE_TABLE_DEPTH = 1024;
  localparam int QTR              = SINE_TABLE_DEPTH / 4;

  // divider width
  localparam int DIV_W = 64;

  // register indexes
  localparam logic [1:0] REG_LEN   = 2'd0;
  localparam logic [1:0] REG_DIR   = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  // odd polynomial coefficients, unsigned q30
  localparam logic [63:0] TC1 = 64'd1686629713;
  localparam logic [63:0] TC3 = 64'd693598668;
  localparam logic [63:0] TC5 = 64'd85569306;
  localparam logic [63:0] TC7 = 64'd5026994;
  localparam logic [63:0] TC9 = 64'd172272;

  typedef struct packed {
    logic signed [15:0] sample_real;
    logic signed [15:0] sample_imag;
  } dds_in_t;

  typedef struct packed {
    logic signed [31:0] result_real;
    logic signed [31:0] result_imag;
    logic [5:0]         bin_index;
    logic               last_bin;
  } dds_out_t;

  typedef enum logic {
    DIV_PHASE,
    DIV_VALUE
  } div_src_t;

  // controller to datapath commands
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             bin_init;
    logic             mac_issue;
    logic [IDX_W-1:0] mac_j;
    logic [IDX_W-1:0] bin_i;
    logic             div_start;
    div_src_t         div_src;
    logic             mul0;
    logic             mul1;
    logic             mul2;
    logic             div_load;
    logic             fin_store;
    logic             fin_sel;
  } dds_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic div_done;
    logic pipe_busy;
  } dds_stat_t;

  typedef logic [14:0] qsin_tab_t [QTR+1];

  // quarter-wave sine magnitude at phase m * 65536 / SINE_TABLE_DEPTH
  function automatic logic [14:0] qsin_entry(int unsigned m);
    logic [63:0] z30;
    logic [63:0] u;
    logic [63:0] acc;
    logic [63:0] q;
    z30 = 64'(m) << 22;
    u   = (z30 * z30) >> 30;
    acc = TC9;
    acc = TC7 - ((acc * u) >> 30);
    acc = TC5 - ((acc * u) >> 30);
    acc = TC3 - ((acc * u) >> 30);
    acc = TC1 - ((acc * u) >> 30);
    acc = (acc * z30) >> 30;
    q   = (acc + 64'd16384) >> 15;
    if (q > 64'd32767) begin
      q = 64'd32767;
    end
    return q[14:0];
  endfunction

  function automatic qsin_tab_t build_qsin();
    qsin_tab_t t;
    for (int m = 0; m <= QTR; m++) begin
      t[m] = qsin_entry(m);
    end
    return t;
  endfunction

  localparam qsin_tab_t QSIN = build_qsin();

  // q1.15 sine of a 16 bit turn phase
  function automatic logic signed [15:0] tw_lookup(logic [15:0] ph);
    logic [9:0]  k;
    logic [8:0]  m;
    logic [15:0] mag;
    k   = ph[15:6];
    m   = k[8] ? (9'(QTR) - {1'b0, k[7:0]}) : {1'b0, k[7:0]};
    mag = {1'b0, QSIN[m]};
    return k[9] ? $signed(-mag) : $signed(mag);
  endfunction

endpackage

@@ rtl/core/dds_stream_if.sv @@
interface dds_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/core/dds_ram.sv @@
module dds_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/core/dds_div.sv @@
module dds_div import dds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [DIV_W-1:0] dividend,
  input  logic [LEN_W-1:0] divisor,
  output logic             busy,
  output logic             done,
  output logic [DIV_W-1:0] quot,
  output logic [LEN_W-1:0] rem
);

  logic                     busy_r;
  logic                     done_r;
  logic [$clog2(DIV_W)-1:0] cnt_r;
  logic [DIV_W-1:0]         q_r;
  logic [LEN_W-1:0]         rem_r;
  logic [LEN_W-1:0]         d_r;
  logic [LEN_W:0]           trial;
  logic [LEN_W:0]           diff;
  logic                     ge;

  // one restoring step per cycle
  assign trial = {rem_r, q_r[DIV_W-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // quotient shifts in where the dividend shifts out
  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= dividend;
      rem_r <= '0;
      d_r   <= divisor;
    end else if (busy_r) begin
      q_r   <= {q_r[DIV_W-2:0], ge};
      rem_r <= ge ? diff[LEN_W-1:0] : trial[LEN_W-1:0];
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;
  assign rem  = rem_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n) start |-> !busy_r)
    else $error("divider started while busy");
  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a run");

endmodule

@@ rtl/core/dds_dp.sv @@
module dds_dp import dds_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  dds_cmd_t           cmd,
  output dds_stat_t          stat,
  input  logic [LEN_W-1:0]   n_eff,
  input  logic [23:0]        scale,
  input  logic               direction,
  input  dds_in_t            in_data,
  output logic signed [31:0] res_real,
  output logic signed [31:0] res_imag
);

  logic [31:0]        rdata;
  logic               div_busy;
  logic               div_done;
  logic [DIV_W-1:0]   div_quot;
  logic [LEN_W-1:0]   div_rem;
  logic [DIV_W-1:0]   div_in;
  logic [29:0]        i_scaled;
  logic [DIV_W-1:0]   v_mag;

  logic [15:0]        qs_r;
  logic [IDX_W-1:0]   rs_r;
  logic [15:0]        q_acc_r;
  logic [IDX_W-1:0]   r_acc_r;
  logic [IDX_W:0]     r_sum;
  logic               wrap;
  logic [IDX_W:0]     r_nxt;

  logic [15:0]        ph0_r;
  logic               v1_r;
  logic               v2_r;
  logic               v3_r;
  logic signed [15:0] s_r;
  logic signed [15:0] c_r;
  logic signed [15:0] xr_r;
  logic signed [15:0] xi_r;
  logic signed [31:0] p_rc_r;
  logic signed [31:0] p_is_r;
  logic signed [31:0] p_ic_r;
  logic signed [31:0] p_rs_r;
  logic signed [47:0] sum_real_r;
  logic signed [47:0] sum_imag_r;

  logic signed [47:0] sel_sum;
  logic [47:0]        p_lo;
  logic signed [24:0] scale_s;
  logic signed [48:0] p_hi;
  logic signed [63:0] prod_r;
  logic signed [63:0] v_r;
  logic signed [63:0] w;
  logic signed [31:0] sat;

  // sample store
  dds_ram #(
    .WIDTH(32),
    .DEPTH(MAX_LEN)
  ) u_store (
    .clk  (clk),
    .we   (cmd.wr_en),
    .waddr(cmd.wr_addr),
    .wdata({in_data.sample_real, in_data.sample_imag}),
    .raddr(cmd.mac_j),
    .rdata(rdata)
  );

  // shared divider: phase step per bin and backward scaling
  assign i_scaled = cmd.bin_i * scale;
  assign v_mag    = v_r[63] ? DIV_W'(-v_r) : DIV_W'(v_r);
  assign div_in   = (cmd.div_src == DIV_VALUE) ? v_mag : {34'd0, i_scaled};

  dds_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (cmd.div_start),
    .dividend(div_in),
    .divisor (n_eff),
    .busy    (div_busy),
    .done    (div_done),
    .quot    (div_quot),
    .rem     (div_rem)
  );

  // phase accumulator: quotient and remainder of i*j*scale/n
  assign r_sum = {1'b0, r_acc_r} + {1'b0, rs_r};
  assign wrap  = r_sum >= n_eff;
  assign r_nxt = wrap ? (r_sum - n_eff) : r_sum;

  always_ff @(posedge clk) begin
    if (cmd.bin_init) begin
      qs_r    <= div_quot[15:0];
      rs_r    <= div_rem[IDX_W-1:0];
      q_acc_r <= '0;
      r_acc_r <= '0;
    end else if (cmd.mac_issue) begin
      ph0_r   <= q_acc_r;
      q_acc_r <= q_acc_r + qs_r + 16'(wrap);
      r_acc_r <= r_nxt[IDX_W-1:0];
    end
  end

  // mac pipeline valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      v1_r <= cmd.mac_issue;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  // twiddle lookup and sample capture
  always_ff @(posedge clk) begin
    if (v1_r) begin
      s_r  <= tw_lookup(ph0_r);
      c_r  <= tw_lookup(ph0_r + 16'h4000);
      xr_r <= rdata[31:16];
      xi_r <= rdata[15:0];
    end
  end

  // complex products
  always_ff @(posedge clk) begin
    if (v2_r) begin
      p_rc_r <= xr_r * c_r;
      p_is_r <= xi_r * s_r;
      p_ic_r <= xi_r * c_r;
      p_rs_r <= xr_r * s_r;
    end
  end

  // accumulate, sign of the sine term set by direction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_real_r <= '0;
      sum_imag_r <= '0;
    end else if (cmd.bin_init) begin
      sum_real_r <= '0;
      sum_imag_r <= '0;
    end else if (v3_r) begin
      if (direction) begin
        sum_real_r <= sum_real_r + 48'(p_rc_r) + 48'(p_is_r);
        sum_imag_r <= sum_imag_r + 48'(p_ic_r) - 48'(p_rs_r);
      end else begin
        sum_real_r <= sum_real_r + 48'(p_rc_r) - 48'(p_is_r);
        sum_imag_r <= sum_imag_r + 48'(p_ic_r) + 48'(p_rs_r);
      end
    end
  end

  // sum times scale in two partial products
  assign sel_sum = cmd.fin_sel ? sum_imag_r : sum_real_r;
  assign p_lo    = sel_sum[23:0] * scale;
  assign scale_s = {1'b0, scale};
  assign p_hi    = $signed(sel_sum[47:24]) * scale_s;

  // round half up to q15 and saturate
  assign w   = v_r + 64'sd1073741824;
  assign sat = (w[63] != w[62]) ? (w[63] ? 32'sh8000_0000 : 32'sh7fff_ffff) : w[62:31];

  always_ff @(posedge clk) begin
    if (cmd.mul0) begin
      prod_r <= {16'd0, p_lo};
    end else if (cmd.mul1) begin
      v_r    <= prod_r;
      prod_r <= 64'(p_hi);
    end else if (cmd.mul2) begin
      v_r <= v_r + (prod_r <<< 24);
    end else if (cmd.div_load) begin
      v_r <= v_r[63] ? $signed(-div_quot) : $signed(div_quot);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.fin_store) begin
      if (cmd.fin_sel) begin
        res_imag <= sat;
      end else begin
        res_real <= sat;
      end
    end
  end

  assign stat.div_done  = div_done;
  assign stat.pipe_busy = v1_r | v2_r | v3_r | div_busy;

endmodule

@@ rtl/core/dds_ctrl.sv @@
module dds_ctrl import dds_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [LEN_W-1:0] n_eff,
  input  logic             direction,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] bin_index,
  output logic             last_bin,
  output dds_cmd_t         cmd,
  input  dds_stat_t        stat
);

  typedef enum logic [3:0] {
    S_LOAD,
    S_DIV_STEP,
    S_WAIT_STEP,
    S_MAC,
    S_DRAIN,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_DIV_VAL,
    S_WAIT_VAL,
    S_ROUND,
    S_OUT
  } state_t;

  state_t           state_r;
  logic [IDX_W-1:0] lc_r;
  logic [IDX_W-1:0] i_r;
  logic [IDX_W-1:0] j_r;
  logic             sel_r;
  logic             in_acc;
  logic [LEN_W-1:0] lc_inc;
  logic             load_done;
  logic             last_j;
  logic             last_i;

  assign in_ready  = (state_r == S_LOAD);
  assign in_acc    = in_ready & in_valid;
  assign lc_inc    = {1'b0, lc_r} + 1'b1;
  assign load_done = lc_inc >= n_eff;
  assign last_j    = {1'b0, j_r} == (n_eff - 1'b1);
  assign last_i    = {1'b0, i_r} == (n_eff - 1'b1);
  assign out_valid = (state_r == S_OUT);
  assign bin_index = i_r;
  assign last_bin  = last_i;

  // command decode
  always_comb begin
    cmd           = '0;
    cmd.wr_en     = in_acc;
    cmd.wr_addr   = lc_r;
    cmd.mac_j     = j_r;
    cmd.bin_i     = i_r;
    cmd.fin_sel   = sel_r;
    cmd.div_src   = DIV_PHASE;
    case (state_r)
      S_DIV_STEP: cmd.div_start = 1'b1;
      S_WAIT_STEP: cmd.bin_init = stat.div_done;
      S_MAC: cmd.mac_issue = 1'b1;
      S_MUL0: cmd.mul0 = 1'b1;
      S_MUL1: cmd.mul1 = 1'b1;
      S_MUL2: cmd.mul2 = 1'b1;
      S_DIV_VAL: begin
        cmd.div_start = 1'b1;
        cmd.div_src   = DIV_VALUE;
      end
      S_WAIT_VAL: begin
        cmd.div_src  = DIV_VALUE;
        cmd.div_load = stat.div_done;
      end
      S_ROUND: cmd.fin_store = 1'b1;
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_LOAD;
      lc_r    <= '0;
      i_r     <= '0;
      j_r     <= '0;
      sel_r   <= 1'b0;
    end else begin
      case (state_r)
        S_LOAD: begin
          if (in_acc) begin
            if (load_done) begin
              lc_r    <= '0;
              i_r     <= '0;
              state_r <= S_DIV_STEP;
            end else begin
              lc_r <= lc_inc[IDX_W-1:0];
            end
          end
        end
        S_DIV_STEP: state_r <= S_WAIT_STEP;
        S_WAIT_STEP: begin
          if (stat.div_done) begin
            j_r     <= '0;
            state_r <= S_MAC;
          end
        end
        S_MAC: begin
          if (last_j) begin
            state_r <= S_DRAIN;
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DRAIN: begin
          if (!stat.pipe_busy) begin
            sel_r   <= 1'b0;
            state_r <= S_MUL0;
          end
        end
        S_MUL0: state_r <= S_MUL1;
        S_MUL1: state_r <= S_MUL2;
        S_MUL2: state_r <= direction ? S_DIV_VAL : S_ROUND;
        S_DIV_VAL: state_r <= S_WAIT_VAL;
        S_WAIT_VAL: begin
          if (stat.div_done) begin
            state_r <= S_ROUND;
          end
        end
        S_ROUND: begin
          if (sel_r) begin
            state_r <= S_OUT;
          end else begin
            sel_r   <= 1'b1;
            state_r <= S_MUL0;
          end
        end
        S_OUT: begin
          if (out_ready) begin
            if (last_i) begin
              i_r     <= '0;
              state_r <= S_LOAD;
            end else begin
              i_r     <= i_r + 1'b1;
              state_r <= S_DIV_STEP;
            end
          end
        end
        default: state_r <= S_LOAD;
      endcase
    end
  end

  a_bin_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ({1'b0, i_r} < n_eff))
    else $error("bin index beyond transform length");
  a_tap_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.mac_issue |-> ({1'b0, j_r} < n_eff))
    else $error("sample index beyond transform length");
  a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(i_r)))
    else $error("pending result dropped");

endmodule

@@ rtl/core/direct_dft_scaled.sv @@
// Direct DFT with scaled phase. Load N complex q1.15 samples (N = transform_length,
// clamped to 1..64), one beat per cycle; the beat that completes the set starts the
// transform, and N result beats follow in bin order, last_bin set on bin N-1. While
// results are computed no sample is taken. A bit-serial divider finds the phase step
// once per bin (and in backward mode divides each of the two scaled sums by N), one
// shared complex MAC takes one sample per cycle, and the final scaling by scale uses
// two partial products per part. Registers sit on an APB-style port at byte offsets
// 0 (transform_length), 4 (direction) and 8 (scale); write them only while the block
// is idle. Sample storage is not cleared at reset.
module direct_dft_scaled import dds_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  dds_stream_if.sink   in_chan,
  dds_stream_if.source out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [LEN_W-1:0]   len_r;
  logic               dir_r;
  logic [23:0]        scale_r;
  logic [LEN_W-1:0]   n_eff;
  logic               cfg_wr;
  dds_cmd_t           cmd;
  dds_stat_t          stat;
  logic signed [31:0] res_real;
  logic signed [31:0] res_imag;
  logic [IDX_W-1:0]   bin_index;
  logic               last_bin;

  // register writes
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r   <= LEN_W'(MAX_LEN);
      dir_r   <= 1'b0;
      scale_r <= 24'h01_0000;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LEN: len_r <= pwdata[LEN_W-1:0];
        REG_DIR: dir_r <= pwdata[0];
        REG_SCALE: scale_r <= pwdata[23:0];
        default: ;
      endcase
    end
  end

  // register reads
  always_comb begin
    case (paddr[3:2])
      REG_LEN: prdata = {25'd0, len_r};
      REG_DIR: prdata = {31'd0, dir_r};
      REG_SCALE: prdata = {8'd0, scale_r};
      default: prdata = '0;
    endcase
  end

  // length clamped to 1..MAX_LEN
  assign n_eff = (len_r == '0) ? LEN_W'(1) :
                 (len_r > LEN_W'(MAX_LEN)) ? LEN_W'(MAX_LEN) : len_r;

  dds_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .n_eff    (n_eff),
    .direction(dir_r),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .out_valid(out_chan.valid),
    .out_ready(out_chan.ready),
    .bin_index(bin_index),
    .last_bin (last_bin),
    .cmd      (cmd),
    .stat     (stat)
  );

  dds_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .stat     (stat),
    .n_eff    (n_eff),
    .scale    (scale_r),
    .direction(dir_r),
    .in_data  (in_chan.data),
    .res_real (res_real),
    .res_imag (res_imag)
  );

  // result beat
  assign out_chan.data.result_real = res_real;
  assign out_chan.data.result_imag = res_imag;
  assign out_chan.data.bin_index   = bin_index;
  assign out_chan.data.last_bin    = last_bin;

endmodule
